// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the bank controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fcb_pkg.sv =====
// Types and constants of the freezer cartridge bank controller.
// No dependencies; used by every module of the block.
package fcb_pkg;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_FREEZE = 3'd2,
        OP_RESET  = 3'd3,
        OP_TICK   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        MODE_NORMAL8K  = 3'd0,
        MODE_NORMAL16K = 3'd1,
        MODE_ULTIMAX   = 3'd2,
        MODE_RAM8K     = 3'd3,
        MODE_RAM16K    = 3'd4
    } t_map_mode;

    localparam logic [15:0] ADDR_CONTROL = 16'hDE00;
    localparam logic [15:0] ADDR_OPTION  = 16'hDE01;
    localparam logic [7:0]  READ_OPEN    = 8'hFF;
    localparam logic [1:0]  FREEZE_DELAY = 2'd3;

    // Option byte masks
    localparam logic [7:0] OPT_FLASH_MASK = 8'hBF;
    localparam logic [7:0] OPT_FIRST_MASK = 8'hDF;
    localparam logic [7:0] OPT_KEEP_MASK  = 8'h46;
    localparam logic [7:0] OPT_WRITE_MASK = 8'h99;
    // Control bits mirrored from the option byte
    localparam logic [7:0] CTL_KEEP_MASK  = 8'h67;
    localparam logic [7:0] CTL_MIRROR_MASK = 8'h98;

    localparam logic       FLASH_MODE_RESET = 1'b0;
    localparam logic [0:0] REG_FLASH_MODE   = 1'b0;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [15:0] elapsed_cycles;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       exrom_line;
        logic       game_line;
        logic       low_window_is_ram;
        logic       high_window_is_ram;
        logic [3:0] active_bank;
        logic [2:0] map_mode;
        logic       cart_enabled;
        logic       frozen;
        logic       nmi_request;
        logic       warm_reset_request;
    } t_result;

endpackage

// ===== rtl/core/freezer_cart_bank_control.sv =====
// Top level of the freezer cartridge bank controller.
// Depends on fcb_pkg, fcb_apb_regs, fcb_engine and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per item:
//   a bus read or write at 0xDE00/0xDE01, a freeze press, a reset press or a
//   tick of elapsed cycles. Output channel (o_out_valid / i_out_ready) returns
//   one result transaction per item: read data plus mapping lines, mode, bank
//   and the NMI / warm reset pulses, all as they stand after the item.
//   An accepted item goes through the input register, then the result register,
//   before o_out_valid rises.
//   The state update is a single pass of logic between the input register and
//   the result register, so items follow without gaps unless the receiver stalls.
//   Receiver stall: the result register holds; the input register keeps one
//   more item, after which o_in_ready drops until the result is taken.
//   Reset (i_rst_n low, synchronous): both pipeline stages empty, control and
//   option bytes cleared, cartridge enabled, unlocked, no freeze pending,
//   flash_mode cleared.
//   APB port: flash_mode at byte address 0, pready always high; write it only
//   while no transaction is in flight.
`include "assert_macros.svh"

module freezer_cart_bank_control (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_elapsed_cycles,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_exrom_line,
    output logic        o_game_line,
    output logic        o_low_window_is_ram,
    output logic        o_high_window_is_ram,
    output logic [3:0]  o_active_bank,
    output logic [2:0]  o_map_mode,
    output logic        o_cart_enabled,
    output logic        o_frozen,
    output logic        o_nmi_request,
    output logic        o_warm_reset_request
);

    logic              flash_mode;
    logic              w_advance;
    fcb_pkg::t_result  w_result;

    // input stage
    logic              r_in_vld;
    fcb_pkg::t_in_item r_in;
    // result stage
    logic              r_out_vld;
    fcb_pkg::t_result  r_out;

    fcb_apb_regs u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_flash_mode (flash_mode)
    );

    // item in the input register moves on when the result slot is free
    assign w_advance  = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_advance;

    fcb_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_item       (r_in),
        .i_flash_mode (flash_mode),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.op             <= i_op;
            r_in.address        <= i_address;
            r_in.write_data     <= i_write_data;
            r_in.elapsed_cycles <= i_elapsed_cycles;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_read_data          = r_out.read_data;
    assign o_exrom_line         = r_out.exrom_line;
    assign o_game_line          = r_out.game_line;
    assign o_low_window_is_ram  = r_out.low_window_is_ram;
    assign o_high_window_is_ram = r_out.high_window_is_ram;
    assign o_active_bank        = r_out.active_bank;
    assign o_map_mode           = r_out.map_mode;
    assign o_cart_enabled       = r_out.cart_enabled;
    assign o_frozen             = r_out.frozen;
    assign o_nmi_request        = r_out.nmi_request;
    assign o_warm_reset_request = r_out.warm_reset_request;

    `FCB_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, w_advance, r_out_vld, "advanced item did not reach the result register")
    `FCB_ASSERT_NOW(a_frozen_mapping, i_clk, i_rst_n, (r_out_vld && r_out.frozen && r_out.cart_enabled), ((r_out.active_bank == 4'd0) && !r_out.exrom_line && r_out.game_line), "freeze result without ultimax bank 0")

endmodule

// ===== rtl/core/fcb_apb_regs.sv =====
// APB configuration register (flash_mode) of the bank controller.
// Depends on fcb_pkg.
module fcb_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_flash_mode
);

    logic r_flash_mode;
    logic n_flash_mode;

    always_comb begin
        n_flash_mode = r_flash_mode;
        if (psel && penable && pwrite && (paddr == fcb_pkg::REG_FLASH_MODE)) begin
            n_flash_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_mode <= fcb_pkg::FLASH_MODE_RESET;
        end else begin
            r_flash_mode <= n_flash_mode;
        end
    end

    assign prdata       = (paddr == fcb_pkg::REG_FLASH_MODE) ? {31'd0, r_flash_mode} : 32'd0;
    assign pready       = 1'b1;
    assign o_flash_mode = r_flash_mode;

endmodule

// ===== rtl/core/fcb_engine.sv =====
// Cartridge state registers and the per-transaction update and mapping decode.
// Depends on fcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fcb_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  fcb_pkg::t_in_item i_item,
    input  logic              i_flash_mode,
    output fcb_pkg::t_result  o_result
);

    logic [7:0] r_control, n_control;
    logic [7:0] r_option,  n_option;
    logic       r_held,    n_held;
    logic       r_waiting, n_waiting;
    logic       r_on,      n_on;
    logic       r_enabled, n_enabled;
    logic       r_locked,  n_locked;
    logic       r_written, n_written;
    logic [1:0] r_delay,   n_delay;

    logic [7:0] opt_new;
    logic [3:0] cur_bank;
    logic [3:0] nxt_bank;
    logic [7:0] status;
    logic [7:0] rd;
    logic       nmi;
    logic       warm;
    fcb_pkg::t_map_mode mode;

    function automatic logic [3:0] bank_of(input logic [7:0] ctl, input logic [7:0] opt,
                                           input logic flash);
        bank_of = {flash & opt[5], ctl[7], ctl[4], ctl[3]};
    endfunction

    function automatic fcb_pkg::t_map_mode mode_of(input logic [7:0] ctl, input logic [7:0] opt);
        fcb_pkg::t_map_mode m;
        if (ctl[5]) begin
            m = opt[1] ? fcb_pkg::MODE_RAM16K : fcb_pkg::MODE_RAM8K;
        end else if (!ctl[0] && !ctl[1]) begin
            m = fcb_pkg::MODE_NORMAL16K;
        end else if (!ctl[0] && ctl[1]) begin
            m = fcb_pkg::MODE_NORMAL8K;
        end else begin
            m = fcb_pkg::MODE_ULTIMAX;
        end
        mode_of = m;
    endfunction

    assign cur_bank = bank_of(r_control, r_option, i_flash_mode);
    // status: b2, opt6, flash bank bit, b1..0, button, opt1, flash
    assign status = {cur_bank[2], r_option[6], i_flash_mode & cur_bank[3], cur_bank[1:0],
                     r_held, r_option[1], i_flash_mode};

    always_comb begin
        n_control = r_control;
        n_option  = r_option;
        n_held    = r_held;
        n_waiting = r_waiting;
        n_on      = r_on;
        n_enabled = r_enabled;
        n_locked  = r_locked;
        n_written = r_written;
        n_delay   = r_delay;
        rd        = 8'd0;
        nmi       = 1'b0;
        warm      = 1'b0;
        opt_new   = r_option;

        case (fcb_pkg::t_op'(i_item.op))
            fcb_pkg::OP_READ: begin
                rd = ((i_item.address == fcb_pkg::ADDR_CONTROL) ||
                      (i_item.address == fcb_pkg::ADDR_OPTION)) ? status : fcb_pkg::READ_OPEN;
            end
            fcb_pkg::OP_WRITE: begin
                if ((i_item.address == fcb_pkg::ADDR_CONTROL) && !r_locked) begin
                    n_control = i_item.write_data;
                    if (r_on) begin
                        if (i_item.write_data[6]) begin
                            // freeze acknowledge
                            n_on      = 1'b0;
                            n_waiting = 1'b0;
                            n_delay   = 2'd0;
                        end else begin
                            n_control = {i_item.write_data[7:2], 2'b01};
                        end
                    end
                    if (i_item.write_data[2]) begin
                        n_locked  = 1'b1;
                        n_enabled = 1'b0;
                    end
                end else if ((i_item.address == fcb_pkg::ADDR_OPTION) && !r_locked) begin
                    if (i_flash_mode) begin
                        opt_new = i_item.write_data & fcb_pkg::OPT_FLASH_MASK;
                    end else if (!r_written) begin
                        opt_new   = i_item.write_data & fcb_pkg::OPT_FIRST_MASK;
                        n_written = 1'b1;
                    end else begin
                        opt_new = (r_option & fcb_pkg::OPT_KEEP_MASK) |
                                  (i_item.write_data & fcb_pkg::OPT_WRITE_MASK);
                    end
                    n_option  = opt_new;
                    n_control = (r_control & fcb_pkg::CTL_KEEP_MASK) |
                                (opt_new & fcb_pkg::CTL_MIRROR_MASK);
                end
            end
            fcb_pkg::OP_FREEZE: begin
                if (!r_option[2] && !r_waiting && !r_on) begin
                    n_held    = 1'b1;
                    n_waiting = 1'b1;
                    n_delay   = fcb_pkg::FREEZE_DELAY;
                    nmi       = 1'b1;
                end
            end
            fcb_pkg::OP_RESET: begin
                n_held    = 1'b0;
                n_waiting = 1'b0;
                n_on      = 1'b0;
                n_enabled = 1'b1;
                n_locked  = 1'b0;
                n_written = 1'b0;
                n_delay   = 2'd0;
                n_control = {r_control[7:3], 1'b0, r_control[1:0]};
                warm      = 1'b1;
            end
            fcb_pkg::OP_TICK: begin
                if (r_waiting && (i_item.elapsed_cycles != 16'd0)) begin
                    if ({14'd0, r_delay} > i_item.elapsed_cycles) begin
                        n_delay = r_delay - i_item.elapsed_cycles[1:0];
                    end else begin
                        n_held    = 1'b0;
                        n_delay   = 2'd0;
                        n_waiting = 1'b0;
                        n_on      = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign nxt_bank = bank_of(n_control, n_option, i_flash_mode);
    assign mode     = n_on ? fcb_pkg::MODE_ULTIMAX : mode_of(n_control, n_option);

    always_comb begin
        o_result                    = '0;
        o_result.read_data          = rd;
        o_result.active_bank        = n_on ? 4'd0 : nxt_bank;
        o_result.map_mode           = mode;
        o_result.cart_enabled       = n_enabled;
        o_result.frozen             = n_on;
        o_result.nmi_request        = nmi;
        o_result.warm_reset_request = warm;
        case (mode)
            fcb_pkg::MODE_NORMAL8K: begin
                o_result.exrom_line = 1'b1;
                o_result.game_line  = 1'b0;
            end
            fcb_pkg::MODE_NORMAL16K: begin
                o_result.exrom_line = 1'b0;
                o_result.game_line  = 1'b0;
            end
            fcb_pkg::MODE_RAM8K: begin
                o_result.exrom_line        = 1'b1;
                o_result.game_line         = 1'b0;
                o_result.low_window_is_ram = 1'b1;
            end
            fcb_pkg::MODE_RAM16K: begin
                o_result.exrom_line         = 1'b0;
                o_result.game_line          = 1'b0;
                o_result.low_window_is_ram  = 1'b1;
                o_result.high_window_is_ram = 1'b1;
            end
            default: begin
                o_result.exrom_line = 1'b0;
                o_result.game_line  = 1'b1;
            end
        endcase
        if (!n_enabled) begin
            // disabled cart: lines released, no overlay
            o_result.exrom_line         = 1'b1;
            o_result.game_line          = 1'b1;
            o_result.low_window_is_ram  = 1'b0;
            o_result.high_window_is_ram = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= 8'd0;
            r_option  <= 8'd0;
            r_held    <= 1'b0;
            r_waiting <= 1'b0;
            r_on      <= 1'b0;
            r_enabled <= 1'b1;
            r_locked  <= 1'b0;
            r_written <= 1'b0;
            r_delay   <= 2'd0;
        end else if (i_step) begin
            r_control <= n_control;
            r_option  <= n_option;
            r_held    <= n_held;
            r_waiting <= n_waiting;
            r_on      <= n_on;
            r_enabled <= n_enabled;
            r_locked  <= n_locked;
            r_written <= n_written;
            r_delay   <= n_delay;
        end
    end

    `FCB_ASSERT_NOW(a_delay_tracks_wait, i_clk, i_rst_n, 1'b1, ((r_delay != 2'd0) == r_waiting), "freeze delay and pending flag disagree")
    `FCB_ASSERT_NOW(a_wait_not_frozen, i_clk, i_rst_n, 1'b1, !(r_waiting && r_on), "freeze pending while freeze mapping active")
    `FCB_ASSERT_NOW(a_lock_disables, i_clk, i_rst_n, 1'b1, (r_enabled != r_locked), "lock and enable flags out of step")

endmodule
